FILE: rtl/core/infix_to_postfix_converter_unit_assert.svh
// assertion macros shared by the converter rtl
`ifndef INFIX_TO_POSTFIX_CONVERTER_UNIT_ASSERT_SVH
`define INFIX_TO_POSTFIX_CONVERTER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// condition in this cycle implies consequence in the same cycle
`define ITP_ASSERT_IMPLY(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("itp assertion failed");

// condition in this cycle implies consequence in the next cycle
`define ITP_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("itp assertion failed");

`else

`define ITP_ASSERT_IMPLY(lbl, ck, rn, ante, cons)
`define ITP_ASSERT_NEXT(lbl, ck, rn, ante, cons)

`endif

`endif

FILE: rtl/core/itp_pkg.sv
package itp_pkg;

    // default operator stack depth
    localparam int ITP_STACK_DEPTH = 32;

    localparam int CODE_W  = 4;
    localparam int VALUE_W = 64;
    localparam int TDATA_W = 72;
    localparam int TUSER_W = 3;

    // input token kinds
    typedef enum logic [2:0] {
        OP_NUMBER   = 3'd0,
        OP_FACT     = 3'd1,
        OP_FUNCTION = 3'd2,
        OP_LPAREN   = 3'd3,
        OP_RPAREN   = 3'd4,
        OP_OPERATOR = 3'd5,
        OP_END      = 3'd6
    } t_op;

    // result token kinds
    typedef enum logic [2:0] {
        OK_NUMBER = 3'd0,
        OK_FACT   = 3'd1,
        OK_FUNC   = 3'd2,
        OK_OPER   = 3'd3,
        OK_END    = 3'd4,
        OK_ERROR  = 3'd5
    } t_kind;

    // error codes
    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_OVERFLOW = 2'd1,
        ERR_RPAREN   = 2'd2,
        ERR_LPAREN   = 2'd3
    } t_err;

    // kind of a stacked entry
    typedef enum logic [1:0] {
        EK_LPAREN = 2'd0,
        EK_FUNC   = 2'd1,
        EK_OPER   = 2'd2
    } t_ekind;

    localparam logic [CODE_W-1:0] CODE_POWER = 4'd5;

    typedef struct packed {
        t_ekind            kind;
        logic [CODE_W-1:0] code;
    } t_entry;

    // commands from the sequencer to the stack
    typedef struct packed {
        logic   push;
        logic   pop;
        logic   clear;
        t_entry push_entry;
    } t_stack_ctrl;

    // stack status back to the sequencer
    typedef struct packed {
        logic   empty;
        logic   full;
        t_entry top;
    } t_stack_stat;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_EMIT,
        S_PUSH,
        S_OPER,
        S_RPAREN,
        S_RP_FUNC,
        S_DRAIN,
        S_END
    } t_state;

    // operator binding strength
    function automatic logic [1:0] prec_of(input logic [CODE_W-1:0] code);
        logic [1:0] p;
        case (code)
            4'd2, 4'd3, 4'd4: p = 2'd1;
            4'd5, 4'd6:       p = 2'd2;
            default:          p = 2'd0;
        endcase
        return p;
    endfunction

endpackage

FILE: rtl/core/itp_cell.sv
module itp_cell (
    input  logic           i_clk,
    input  logic           i_push,
    input  logic           i_pop,
    input  itp_pkg::t_entry i_from_above,
    input  itp_pkg::t_entry i_from_below,
    output itp_pkg::t_entry o_entry
);
    import itp_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // shift toward the bottom on push, toward the top on pop
    always_comb begin
        if (i_push) begin
            n_entry = i_from_above;
        end else if (i_pop) begin
            n_entry = i_from_below;
        end else begin
            n_entry = r_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

FILE: rtl/core/itp_stack.sv
module itp_stack #(
    parameter int STACK_DEPTH = itp_pkg::ITP_STACK_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  itp_pkg::t_stack_ctrl i_ctrl,
    output itp_pkg::t_stack_stat o_stat
);
    import itp_pkg::*;

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);

    t_entry           w_cell [STACK_DEPTH];
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    // row of cells, cell 0 holds the top of stack
    for (genvar gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
        t_entry w_above;
        t_entry w_below;

        if (gi == 0) begin : g_top
            assign w_above = i_ctrl.push_entry;
        end else begin : g_mid
            assign w_above = w_cell[gi-1];
        end

        if (gi == STACK_DEPTH - 1) begin : g_bot
            assign w_below = '0;
        end else begin : g_up
            assign w_below = w_cell[gi+1];
        end

        itp_cell u_cell (
            .i_clk        (i_clk),
            .i_push       (i_ctrl.push),
            .i_pop        (i_ctrl.pop),
            .i_from_above (w_above),
            .i_from_below (w_below),
            .o_entry      (w_cell[gi])
        );
    end

    // fill count
    always_comb begin
        if (i_ctrl.clear) begin
            n_count = '0;
        end else if (i_ctrl.push) begin
            n_count = r_count + 1'b1;
        end else if (i_ctrl.pop) begin
            n_count = r_count - 1'b1;
        end else begin
            n_count = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == CNT_W'(STACK_DEPTH));
    assign o_stat.top   = w_cell[0];

endmodule

FILE: rtl/core/infix_to_postfix_converter_unit.sv
// Infix to postfix converter: infix tokens enter on the slave stream, one at a time, and
// postfix tokens leave on the master stream in order, the end marker flagged by tlast.
// Operators wait in a shift-register stack of STACK_DEPTH cells whose top sits in the
// first cell, so every push or pop is a single shift of the whole row. One item is taken
// at a time and each emitted entry leaves through the single output register in its own
// cycle. Numbers and factorial are emitted; functions and left parentheses are pushed,
// or flag an overflow when the stack is full; an operator pops functions and entries that
// bind tighter, or as tight but for the power operator, and is then pushed; a right
// parenthesis pops the entries above its partner, drops the partner and lets a function
// below it leave, or flags an error when no partner is found; an end token pops every
// stacked entry before the end marker, or emits only the marker when an error is latched.
// After an error every token up to the end token is swallowed, as is an unknown token kind;
// the end marker carries the error code. Master back-pressure stalls every emitting step.
`include "infix_to_postfix_converter_unit_assert.svh"

module infix_to_postfix_converter_unit #(
    parameter int STACK_DEPTH = itp_pkg::ITP_STACK_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // slave side
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // token_code [3:0], operand_value [67:4], zero fill [71:68]
    input  logic [itp_pkg::TDATA_W-1:0] i_s_axis_tdata,
    // operation [2:0]
    input  logic [itp_pkg::TUSER_W-1:0] i_s_axis_tuser,
    // master side
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    // out_code [3:0], out_value [67:4], error_code [69:68], zero fill [71:70]
    output logic [itp_pkg::TDATA_W-1:0] o_m_axis_tdata,
    // out_kind [2:0]
    output logic [itp_pkg::TUSER_W-1:0] o_m_axis_tuser,
    output logic                        o_m_axis_tlast
);
    import itp_pkg::*;

    t_state              r_state;
    t_state              n_state;
    t_op                 r_op;
    logic [CODE_W-1:0]   r_code;
    logic [VALUE_W-1:0]  r_value;
    t_err                r_err;
    t_err                r_end_err;

    logic                r_out_valid;
    t_kind               r_out_kind;
    logic [CODE_W-1:0]   r_out_code;
    logic [VALUE_W-1:0]  r_out_value;
    t_err                r_out_err;
    logic                r_out_last;

    t_stack_ctrl         w_ctrl;
    t_stack_stat         w_stat;

    logic                w_accept;
    t_op                 w_in_op;
    logic                w_out_free;
    logic                w_oper_pop;
    logic                w_emit;
    t_kind               w_out_kind;
    logic [CODE_W-1:0]   w_out_code;
    logic [VALUE_W-1:0]  w_out_value;
    t_err                w_out_err;
    logic                w_out_last;
    logic                w_set_err;
    t_err                w_set_err_code;
    logic                w_set_lp_err;
    logic                w_clear_err;
    t_kind               w_top_kind;
    logic                w_err_swallow;

    assign w_in_op    = t_op'(i_s_axis_tuser);
    assign w_accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free = !r_out_valid || i_m_axis_tready;
    assign w_top_kind = (w_stat.top.kind == EK_FUNC) ? OK_FUNC : OK_OPER;

    // item taken while an error is latched and not the end token
    assign w_err_swallow = w_accept && (r_err != ERR_NONE) && (w_in_op != OP_END);

    // top pops: a function, or an operator that binds tighter, or as tight but not power
    assign w_oper_pop = !w_stat.empty && (w_stat.top.kind != EK_LPAREN) &&
                        ((w_stat.top.kind == EK_FUNC) ||
                         (prec_of(w_stat.top.code) > prec_of(r_code)) ||
                         ((prec_of(w_stat.top.code) == prec_of(r_code)) &&
                          (w_stat.top.code != CODE_POWER)));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (w_in_op == OP_END) begin
                        n_state = (r_err != ERR_NONE) ? S_END : S_DRAIN;
                    end else if (r_err != ERR_NONE) begin
                        n_state = S_IDLE;
                    end else begin
                        case (w_in_op)
                            OP_NUMBER, OP_FACT:     n_state = S_EMIT;
                            OP_FUNCTION, OP_LPAREN: n_state = S_PUSH;
                            OP_RPAREN:              n_state = S_RPAREN;
                            OP_OPERATOR:            n_state = S_OPER;
                            default:                n_state = S_IDLE;
                        endcase
                    end
                end
            end
            S_EMIT: begin
                if (w_out_free) n_state = S_IDLE;
            end
            S_PUSH: begin
                if (!w_stat.full || w_out_free) n_state = S_IDLE;
            end
            S_OPER: begin
                if (!w_oper_pop) n_state = S_PUSH;
            end
            S_RPAREN: begin
                if (w_stat.empty) begin
                    if (w_out_free) n_state = S_IDLE;
                end else if (w_stat.top.kind == EK_LPAREN) begin
                    n_state = S_RP_FUNC;
                end
            end
            S_RP_FUNC: begin
                if (w_stat.empty || w_stat.top.kind != EK_FUNC || w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_DRAIN: begin
                if (w_stat.empty) n_state = S_END;
            end
            S_END: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer outputs: stack commands and result fields
    always_comb begin
        o_s_axis_tready   = 1'b0;
        w_ctrl.push       = 1'b0;
        w_ctrl.pop        = 1'b0;
        w_ctrl.clear      = 1'b0;
        w_ctrl.push_entry = '{kind: EK_OPER, code: r_code};
        w_emit            = 1'b0;
        w_out_kind        = OK_NUMBER;
        w_out_code        = '0;
        w_out_value       = '0;
        w_out_err         = ERR_NONE;
        w_out_last        = 1'b0;
        w_set_err         = 1'b0;
        w_set_err_code    = ERR_NONE;
        w_set_lp_err      = 1'b0;
        w_clear_err       = 1'b0;
        case (r_op)
            OP_FUNCTION: w_ctrl.push_entry = '{kind: EK_FUNC, code: r_code};
            OP_LPAREN:   w_ctrl.push_entry = '{kind: EK_LPAREN, code: '0};
            default:     w_ctrl.push_entry = '{kind: EK_OPER, code: r_code};
        endcase
        case (r_state)
            S_IDLE: begin
                o_s_axis_tready = i_rst_n;
            end
            S_EMIT: begin
                w_emit      = w_out_free;
                w_out_kind  = (r_op == OP_NUMBER) ? OK_NUMBER : OK_FACT;
                w_out_value = (r_op == OP_NUMBER) ? r_value : '0;
            end
            S_PUSH: begin
                if (w_stat.full) begin
                    w_emit         = w_out_free;
                    w_out_kind     = OK_ERROR;
                    w_out_err      = ERR_OVERFLOW;
                    w_set_err      = w_out_free;
                    w_set_err_code = ERR_OVERFLOW;
                end else begin
                    w_ctrl.push = 1'b1;
                end
            end
            S_OPER: begin
                if (w_oper_pop) begin
                    w_emit      = w_out_free;
                    w_ctrl.pop  = w_out_free;
                    w_out_kind  = w_top_kind;
                    w_out_code  = w_stat.top.code;
                end
            end
            S_RPAREN: begin
                if (w_stat.empty) begin
                    w_emit         = w_out_free;
                    w_out_kind     = OK_ERROR;
                    w_out_err      = ERR_RPAREN;
                    w_set_err      = w_out_free;
                    w_set_err_code = ERR_RPAREN;
                end else if (w_stat.top.kind == EK_LPAREN) begin
                    w_ctrl.pop = 1'b1;
                end else begin
                    w_emit     = w_out_free;
                    w_ctrl.pop = w_out_free;
                    w_out_kind = w_top_kind;
                    w_out_code = w_stat.top.code;
                end
            end
            S_RP_FUNC: begin
                if (!w_stat.empty && w_stat.top.kind == EK_FUNC) begin
                    w_emit     = w_out_free;
                    w_ctrl.pop = w_out_free;
                    w_out_kind = OK_FUNC;
                    w_out_code = w_stat.top.code;
                end
            end
            S_DRAIN: begin
                if (!w_stat.empty) begin
                    if (w_stat.top.kind == EK_LPAREN) begin
                        w_ctrl.pop   = 1'b1;
                        w_set_lp_err = 1'b1;
                    end else begin
                        w_emit     = w_out_free;
                        w_ctrl.pop = w_out_free;
                        w_out_kind = w_top_kind;
                        w_out_code = w_stat.top.code;
                    end
                end
            end
            S_END: begin
                w_emit       = w_out_free;
                w_out_kind   = OK_END;
                w_out_err    = r_end_err;
                w_out_last   = 1'b1;
                w_ctrl.clear = w_out_free;
                w_clear_err  = w_out_free;
            end
            default: begin
                o_s_axis_tready = 1'b0;
            end
        endcase
    end

    itp_stack #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .o_stat  (w_stat)
    );

    // control state and error tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_err     <= ERR_NONE;
            r_end_err <= ERR_NONE;
        end else begin
            r_state <= n_state;
            if (w_clear_err) begin
                r_err <= ERR_NONE;
            end else if (w_set_err) begin
                r_err <= w_set_err_code;
            end
            if (w_accept && w_in_op == OP_END) begin
                r_end_err <= r_err;
            end else if (w_set_lp_err) begin
                r_end_err <= ERR_LPAREN;
            end
        end
    end

    // captured item
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op    <= w_in_op;
            r_code  <= i_s_axis_tdata[CODE_W-1:0];
            r_value <= i_s_axis_tdata[CODE_W +: VALUE_W];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_kind  <= w_out_kind;
            r_out_code  <= w_out_code;
            r_out_value <= w_out_value;
            r_out_err   <= w_out_err;
            r_out_last  <= w_out_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b00, r_out_err, r_out_value, r_out_code};
    assign o_m_axis_tuser  = r_out_kind;
    assign o_m_axis_tlast  = r_out_last;

    `ITP_ASSERT_IMPLY(a_emit_has_room, i_clk, i_rst_n, w_emit, w_out_free)
    `ITP_ASSERT_IMPLY(a_no_push_full, i_clk, i_rst_n, w_ctrl.push, !w_stat.full)
    `ITP_ASSERT_IMPLY(a_no_pop_empty, i_clk, i_rst_n, w_ctrl.pop, !w_stat.empty)
    `ITP_ASSERT_NEXT(a_err_swallow, i_clk, i_rst_n, w_err_swallow, r_state == S_IDLE)

endmodule
